FILE: src/trpc_pkg.sv
// ----------------------------------------------------------------------------
// trpc_pkg
// Shared types and constants for the rate to prescale and compare pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trpc_pkg;

   localparam int unsigned COUNTER_BITS     = 8;
   localparam int unsigned NUM_SHIFTS       = 7;
   localparam int unsigned SLOW_LIMIT_SHIFT = 18;
   localparam int unsigned RATE_W           = 32;
   localparam int unsigned NUM_W            = RATE_W + 1;
   localparam int unsigned QUO_W            = COUNTER_BITS + 1;
   localparam int unsigned CMP_W            = COUNTER_BITS;
   localparam int unsigned SHIFT_W          = 5;

   localparam logic [2:0]       CODE_FASTEST = 3'd1;
   localparam logic [2:0]       CODE_SLOWEST = 3'd7;
   localparam logic [CMP_W-1:0] MAX_COMPARE  = {CMP_W{1'b1}};
   localparam logic [RATE_W-1:0] CLOCK_RESET = 32'd16000000;

   typedef enum logic [1:0] {
      STATUS_IN_RANGE = 2'd0,
      STATUS_TOO_FAST = 2'd1,
      STATUS_TOO_SLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0] code;
      status_type status;
   } meta_type;

   function automatic logic [SHIFT_W-1:0] shift_of(input logic [2:0] idx);
      logic [SHIFT_W-1:0] s;
      unique case (idx)
         3'd0:    s = 5'd0;
         3'd1:    s = 5'd3;
         3'd2:    s = 5'd5;
         3'd3:    s = 5'd6;
         3'd4:    s = 5'd7;
         3'd5:    s = 5'd8;
         3'd6:    s = 5'd10;
         default: s = 5'd10;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: src/timer_rate_to_prescale_compare.sv
// ----------------------------------------------------------------------------
// timer_rate_to_prescale_compare
// Requested interrupt rate in, prescaler code and 8-bit compare value out.
//
// Request channel: req_valid / req_stall carry req_requested_rate_hz.
// Response channel: rsp_valid / rsp_stall carry rsp_prescale_code,
// rsp_compare_value and rsp_range_status (0 in range, 1 too fast,
// 2 too slow). csr_write_enable / csr_write_data set the timer clock in
// hertz; write it only while no request is in flight.
// Stages: one for the range check and shift choice, one for the rounded
// numerator, nine for the quotient (one restoring division bit per stage)
// and the output register. A new request is taken every cycle while rsp_stall
// is low. When rsp_stall is high the pipeline holds, empty stages still fill,
// and req_stall rises once every stage is occupied.
// Reset empties the pipeline and sets the clock register to 16 MHz.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timer_rate_to_prescale_compare (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [31:0]  req_requested_rate_hz,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_prescale_code,
   output logic [7:0]        rsp_compare_value,
   output logic [1:0]        rsp_range_status,
   input  wire logic         csr_write_enable,
   input  wire logic [31:0]  csr_write_data
);

   localparam int unsigned NSTG = trpc_pkg::QUO_W;

   logic [trpc_pkg::RATE_W-1:0]  cpu_clock_hz_ff, cpu_clock_hz_in;
   logic                         sel_ready;

   logic                         d_valid [NSTG+1];
   logic                         d_ready [NSTG+1];
   logic [trpc_pkg::NUM_W-1:0]   d_rem   [NSTG+1];
   logic [trpc_pkg::QUO_W-1:0]   d_quo   [NSTG+1];
   logic [trpc_pkg::RATE_W-1:0]  d_rate  [NSTG+1];
   trpc_pkg::meta_type           d_meta  [NSTG+1];

   assign cpu_clock_hz_in = csr_write_enable ? csr_write_data : cpu_clock_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_clock_hz_ff <= trpc_pkg::CLOCK_RESET;
      end else begin
         cpu_clock_hz_ff <= cpu_clock_hz_in;
      end
   end

   assign req_stall = !sel_ready;
   assign d_quo[0]  = '0;

   trpc_select u_select (
      .clock     (clock),
      .reset     (reset),
      .clk_hz    (cpu_clock_hz_ff),
      .in_valid  (req_valid),
      .in_ready  (sel_ready),
      .in_rate   (req_requested_rate_hz),
      .out_valid (d_valid[0]),
      .out_ready (d_ready[0]),
      .out_num   (d_rem[0]),
      .out_rate  (d_rate[0]),
      .out_meta  (d_meta[0])
   );

   // Quotient bits from the top down.
   for (genvar k = 0; k < NSTG; k++) begin : g_div
      trpc_div_stage #(.BIT(NSTG - 1 - k)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (d_valid[k]),
         .in_ready  (d_ready[k]),
         .in_rem    (d_rem[k]),
         .in_quo    (d_quo[k]),
         .in_rate   (d_rate[k]),
         .in_meta   (d_meta[k]),
         .out_valid (d_valid[k+1]),
         .out_ready (d_ready[k+1]),
         .out_rem   (d_rem[k+1]),
         .out_quo   (d_quo[k+1]),
         .out_rate  (d_rate[k+1]),
         .out_meta  (d_meta[k+1])
      );
   end

   trpc_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid[NSTG]),
      .in_ready    (d_ready[NSTG]),
      .in_quo      (d_quo[NSTG]),
      .in_meta     (d_meta[NSTG]),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_code    (rsp_prescale_code),
      .out_compare (rsp_compare_value),
      .out_status  (rsp_range_status)
   );

endmodule

`default_nettype wire

FILE: src/trpc_select.sv
// ----------------------------------------------------------------------------
// trpc_select
// Range check and prescaler choice, then the rounded numerator; two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trpc_select (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [trpc_pkg::RATE_W-1:0]    clk_hz,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [trpc_pkg::RATE_W-1:0]    in_rate,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [trpc_pkg::NUM_W-1:0]          out_num,
   output logic [trpc_pkg::RATE_W-1:0]         out_rate,
   output trpc_pkg::meta_type                  out_meta
);

   logic                         found;
   logic [2:0]                   idx;
   logic                         too_fast;
   logic                         too_slow;
   trpc_pkg::meta_type           meta_in;

   logic                         v1_ff, v1_in;
   logic                         rdy1;
   logic [trpc_pkg::RATE_W-1:0]  top_ff, top_in;
   logic [trpc_pkg::RATE_W-1:0]  rate1_ff;
   trpc_pkg::meta_type           meta1_ff;

   logic                         v2_ff, v2_in;
   logic                         rdy2;
   logic [trpc_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [trpc_pkg::RATE_W-1:0]  rate2_ff;
   trpc_pkg::meta_type           meta2_ff;

   // Lowest matching shift index wins: scan from the slowest down, later matches overwrite.
   always_comb begin
      found = 1'b0;
      idx   = 3'd0;
      for (int i = trpc_pkg::NUM_SHIFTS - 1; i >= 0; i--) begin
         if (in_rate > (clk_hz >> (trpc_pkg::shift_of(3'(i)) + 5'(trpc_pkg::COUNTER_BITS))))
         begin
            found = 1'b1;
            idx   = 3'(i);
         end
      end
   end

   always_comb begin
      too_fast = in_rate > clk_hz;
      too_slow = in_rate < (clk_hz >> trpc_pkg::SLOW_LIMIT_SHIFT);
      top_in   = clk_hz >> trpc_pkg::shift_of(idx);
      priority if (too_fast) begin
         meta_in.code   = trpc_pkg::CODE_FASTEST;
         meta_in.status = trpc_pkg::STATUS_TOO_FAST;
      end else if (too_slow || !found) begin
         meta_in.code   = trpc_pkg::CODE_SLOWEST;
         meta_in.status = trpc_pkg::STATUS_TOO_SLOW;
      end else begin
         meta_in.code   = idx + 3'd1;
         meta_in.status = trpc_pkg::STATUS_IN_RANGE;
      end
   end

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign v1_in    = rdy1 ? in_valid : v1_ff;
   assign v2_in    = rdy2 ? v1_ff : v2_ff;
   assign num_in   = {1'b0, top_ff} + {2'b0, rate1_ff[trpc_pkg::RATE_W-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         top_ff   <= top_in;
         rate1_ff <= in_rate;
         meta1_ff <= meta_in;
      end
      if (rdy2 && v1_ff) begin
         num_ff   <= num_in;
         rate2_ff <= rate1_ff;
         meta2_ff <= meta1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_num   = num_ff;
   assign out_rate  = rate2_ff;
   assign out_meta  = meta2_ff;

endmodule

`default_nettype wire

FILE: src/trpc_div_stage.sv
// ----------------------------------------------------------------------------
// trpc_div_stage
// One restoring-division step: settle quotient bit BIT and register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trpc_div_stage #(
   parameter int unsigned BIT = 0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [trpc_pkg::NUM_W-1:0]     in_rem,
   input  wire logic [trpc_pkg::QUO_W-1:0]     in_quo,
   input  wire logic [trpc_pkg::RATE_W-1:0]    in_rate,
   input  wire trpc_pkg::meta_type             in_meta,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [trpc_pkg::NUM_W-1:0]          out_rem,
   output logic [trpc_pkg::QUO_W-1:0]          out_quo,
   output logic [trpc_pkg::RATE_W-1:0]         out_rate,
   output trpc_pkg::meta_type                  out_meta
);

   localparam int unsigned EXT_W = trpc_pkg::RATE_W + trpc_pkg::QUO_W + 1;

   logic [EXT_W-1:0]              rem_x, den_x, diff;
   logic                          take;
   logic                          ready;
   logic                          valid_ff, valid_in;
   logic [trpc_pkg::NUM_W-1:0]    rem_ff, rem_in;
   logic [trpc_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic [trpc_pkg::RATE_W-1:0]   rate_ff;
   trpc_pkg::meta_type            meta_ff;

   always_comb begin
      rem_x  = EXT_W'(in_rem);
      den_x  = EXT_W'(in_rate) << BIT;
      diff   = rem_x - den_x;
      take   = rem_x >= den_x;
      rem_in = take ? diff[trpc_pkg::NUM_W-1:0] : in_rem;
      quo_in = in_quo;
      quo_in[BIT] = take;
   end

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;
   assign valid_in = ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         rate_ff <= in_rate;
         meta_ff <= in_meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_rate  = rate_ff;
   assign out_meta  = meta_ff;

endmodule

`default_nettype wire

FILE: src/trpc_finish.sv
// ----------------------------------------------------------------------------
// trpc_finish
// Turn the quotient into a clamped compare value; output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trpc_finish (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [trpc_pkg::QUO_W-1:0]    in_quo,
   input  wire trpc_pkg::meta_type            in_meta,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [2:0]                         out_code,
   output logic [trpc_pkg::CMP_W-1:0]         out_compare,
   output logic [1:0]                         out_status
);

   logic [trpc_pkg::QUO_W-1:0]   dec;
   logic [trpc_pkg::CMP_W-1:0]   cmp_in, cmp_ff;
   trpc_pkg::meta_type           meta_ff;
   logic                         ready;
   logic                         valid_ff, valid_in;

   always_comb begin
      dec = in_quo - trpc_pkg::QUO_W'(1);
      priority if (in_meta.status == trpc_pkg::STATUS_TOO_FAST) begin
         cmp_in = '0;
      end else if (in_meta.status == trpc_pkg::STATUS_TOO_SLOW) begin
         cmp_in = trpc_pkg::MAX_COMPARE;
      end else if (in_quo == '0) begin
         cmp_in = '0;
      end else if (dec > trpc_pkg::QUO_W'(trpc_pkg::MAX_COMPARE)) begin
         cmp_in = trpc_pkg::MAX_COMPARE;
      end else begin
         cmp_in = dec[trpc_pkg::CMP_W-1:0];
      end
   end

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;
   assign valid_in = ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         cmp_ff  <= cmp_in;
         meta_ff <= in_meta;
      end
   end

   assign out_valid   = valid_ff;
   assign out_code    = meta_ff.code;
   assign out_compare = cmp_ff;
   assign out_status  = meta_ff.status;

endmodule

`default_nettype wire

FILE: src/trpc_checker.sv
// ----------------------------------------------------------------------------
// trpc_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trpc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_prescale_code,
   input  wire logic [7:0]  rsp_compare_value,
   input  wire logic [1:0]  rsp_range_status
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_fast_sat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_status == trpc_pkg::STATUS_TOO_FAST) |->
      (rsp_prescale_code == trpc_pkg::CODE_FASTEST && rsp_compare_value == 8'd0))
      else $error("too-fast response not saturated");

   a_slow_sat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_status == trpc_pkg::STATUS_TOO_SLOW) |->
      (rsp_prescale_code == trpc_pkg::CODE_SLOWEST &&
       rsp_compare_value == trpc_pkg::MAX_COMPARE))
      else $error("too-slow response not saturated");

   a_code_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prescale_code != 3'd0 && rsp_range_status != 2'd3))
      else $error("response code or status out of range");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_compare_value)))
      else $error("stalled response changed");

endmodule

bind timer_rate_to_prescale_compare trpc_checker u_trpc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_prescale_code (rsp_prescale_code),
   .rsp_compare_value (rsp_compare_value),
   .rsp_range_status  (rsp_range_status)
);

`default_nettype wire
